// ===== hdl/nsgs_pkg.sv =====
package nsgs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SIDE      = 64;
    localparam int DEF_WEIGHT_BITS   = 16;
    localparam int DEF_GRADIENT_BITS = 32;

    // Configuration register layout.
    localparam int DECAY_BITS     = 16;
    localparam int SIDE_CFG_BITS  = 7;
    localparam int COUNT_CFG_BITS = 11;
    localparam int MAP_POS_BITS   = 10;
    localparam int MAP_LIMIT      = 1024;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SIDE_RESET     = 16;
    localparam int COUNT_RESET    = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT = 2'd2;

    // Four decay steps of either sign fit in this many signed bits.
    localparam int NET_BITS = DECAY_BITS + 3;

    // Entries in the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // What the front learned about one item: which results it causes and
    // which neighbors of those results lie inside the map.
    typedef struct packed {
        logic has_main;   // result of the element one row up
        logic has_tail;   // last row: result of the element to the left
        logic has_fin;    // last element: its own result
        logic col_gt0;
        logic col_gt1;
        logic right_ok;
        logic row_gt0;
        logic row_gt1;
        logic last_map;
    } job_flags_t;

    localparam int FLAGS_BITS = $bits(job_flags_t);

endpackage

// ===== hdl/nsgs_fifo.sv =====
module nsgs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = nsgs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    import nsgs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/nsgs_front.sv =====
module nsgs_front #(
    parameter int MAX_SIDE      = nsgs_pkg::DEF_MAX_SIDE,
    parameter int WEIGHT_BITS   = nsgs_pkg::DEF_WEIGHT_BITS,
    parameter int GRADIENT_BITS = nsgs_pkg::DEF_GRADIENT_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [WEIGHT_BITS-1:0]          weight_value,
    input  logic signed [GRADIENT_BITS-1:0]        gradient_in,
    input  logic                                   cfg_write,
    input  logic [nsgs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [nsgs_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output logic                                   job_valid,
    input  logic                                   job_ready,
    output nsgs_pkg::job_flags_t                   job_flags,
    output logic signed [WEIGHT_BITS-1:0]          w_cur,
    output logic signed [WEIGHT_BITS-1:0]          w_prev,
    output logic signed [WEIGHT_BITS-1:0]          w_prev2,
    output logic signed [WEIGHT_BITS-1:0]          w_up1,
    output logic signed [WEIGHT_BITS-1:0]          w_up2,
    output logic signed [WEIGHT_BITS-1:0]          w_right,
    output logic signed [WEIGHT_BITS-1:0]          w_left_up,
    output logic signed [GRADIENT_BITS-1:0]        g_cur,
    output logic signed [GRADIENT_BITS-1:0]        g_prev,
    output logic signed [GRADIENT_BITS-1:0]        g_up
);
    import nsgs_pkg::*;

    localparam int COL_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int SIDE_INIT = (MAX_SIDE < SIDE_RESET) ? MAX_SIDE : SIDE_RESET;

    // Configuration and position state.
    logic [SIDE_W-1:0]         side_reg, side_next;
    logic [COUNT_CFG_BITS-1:0] count_reg, count_next;
    logic [COL_W-1:0]          row_reg, row_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [MAP_POS_BITS-1:0]   map_reg, map_next;
    logic                      s1_valid_reg, s1_valid_next;

    // Line stores: even and odd map rows of weights, and the gradients of
    // the row above.
    logic signed [WEIGHT_BITS-1:0]   even_mem [MAX_SIDE];
    logic signed [WEIGHT_BITS-1:0]   odd_mem  [MAX_SIDE];
    logic signed [GRADIENT_BITS-1:0] grad_mem [MAX_SIDE];

    // Job stage, loaded at each accepted beat.
    logic signed [WEIGHT_BITS-1:0]   w_cur_reg, w_prev_reg, w_prev2_reg;
    logic signed [WEIGHT_BITS-1:0]   w_up1_reg, w_up2_reg, w_right_reg, w_left_up_reg;
    logic signed [GRADIENT_BITS-1:0] g_cur_reg, g_prev_reg, g_up_reg;
    job_flags_t                      flags_reg, flags_next;

    logic                      accept;
    logic [SIDE_W-1:0]         col_ext;
    logic [SIDE_W-1:0]         row_ext;
    logic [SIDE_W-1:0]         col_inc;
    logic [SIDE_W-1:0]         row_inc;
    logic                      col_last;
    logic                      row_last;
    logic                      map_last;
    logic [COL_W-1:0]          col_up;
    logic                      pos_clear;
    logic [SIDE_CFG_BITS-1:0]  side_cfg;
    logic [COUNT_CFG_BITS-1:0] count_cfg;

    assign full   = s1_valid_reg && !job_ready;
    assign accept = push && !full;

    assign col_ext  = SIDE_W'(col_reg);
    assign row_ext  = SIDE_W'(row_reg);
    assign col_inc  = col_ext + SIDE_W'(1);
    assign row_inc  = row_ext + SIDE_W'(1);
    assign col_last = (col_inc == side_reg);
    assign row_last = (row_inc == side_reg);
    assign map_last = ((COUNT_CFG_BITS'(map_reg) + COUNT_CFG_BITS'(1)) == count_reg);
    assign col_up   = COL_W'(col_inc);

    assign side_cfg  = cfg_data[SIDE_CFG_BITS-1:0];
    assign count_cfg = cfg_data[COUNT_CFG_BITS-1:0];
    assign pos_clear = cfg_write && ((cfg_index == REG_SIDE) || (cfg_index == REG_COUNT));

    always_comb
    begin
        flags_next.has_main = (row_reg != '0);
        flags_next.has_tail = row_last && (col_reg != '0);
        flags_next.has_fin  = row_last && col_last;
        flags_next.col_gt0  = (col_reg != '0);
        flags_next.col_gt1  = (col_reg > COL_W'(1));
        flags_next.right_ok = !col_last;
        flags_next.row_gt0  = (row_reg != '0);
        flags_next.row_gt1  = (row_reg > COL_W'(1));
        flags_next.last_map = map_last;
    end

    always_comb
    begin
        side_next  = side_reg;
        count_next = count_reg;
        if (cfg_write && (cfg_index == REG_SIDE))
        begin
            if (side_cfg == '0)
            begin
                side_next = SIDE_W'(1);
            end
            else if (int'(side_cfg) > MAX_SIDE)
            begin
                side_next = SIDE_W'(MAX_SIDE);
            end
            else
            begin
                side_next = SIDE_W'(side_cfg);
            end
        end
        if (cfg_write && (cfg_index == REG_COUNT))
        begin
            if (count_cfg == '0)
            begin
                count_next = COUNT_CFG_BITS'(1);
            end
            else if (int'(count_cfg) > MAP_LIMIT)
            begin
                count_next = COUNT_CFG_BITS'(MAP_LIMIT);
            end
            else
            begin
                count_next = count_cfg;
            end
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        map_next = map_reg;
        if (pos_clear)
        begin
            row_next = '0;
            col_next = '0;
            map_next = '0;
        end
        else if (accept)
        begin
            if (!col_last)
            begin
                col_next = COL_W'(col_inc);
            end
            else
            begin
                col_next = '0;
                if (!row_last)
                begin
                    row_next = COL_W'(row_inc);
                end
                else
                begin
                    row_next = '0;
                    map_next = map_last ? '0 : map_reg + MAP_POS_BITS'(1);
                end
            end
        end
    end

    // A beat that causes no result leaves no job behind.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = flags_next.has_main || flags_next.has_tail || flags_next.has_fin;
        end
        else if (job_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= SIDE_W'(SIDE_INIT);
            count_reg    <= COUNT_CFG_BITS'(COUNT_RESET);
            row_reg      <= '0;
            col_reg      <= '0;
            map_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            side_reg     <= side_next;
            count_reg    <= count_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            map_reg      <= map_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // The bank of the current row still holds the row two above, which is
    // read out before it is overwritten. The other bank holds the row above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_cur_reg      <= weight_value;
            g_cur_reg      <= gradient_in;
            w_prev_reg     <= w_cur_reg;
            w_prev2_reg    <= w_prev_reg;
            g_prev_reg     <= g_cur_reg;
            w_left_up_reg  <= w_up1_reg;
            flags_reg      <= flags_next;
            g_up_reg          <= grad_mem[col_reg];
            grad_mem[col_reg] <= gradient_in;
            if (!row_reg[0])
            begin
                w_up2_reg         <= even_mem[col_reg];
                even_mem[col_reg] <= weight_value;
                w_up1_reg         <= odd_mem[col_reg];
                w_right_reg       <= odd_mem[col_up];
            end
            else
            begin
                w_up2_reg         <= odd_mem[col_reg];
                odd_mem[col_reg]  <= weight_value;
                w_up1_reg         <= even_mem[col_reg];
                w_right_reg       <= even_mem[col_up];
            end
        end
    end

    assign job_valid = s1_valid_reg;
    assign job_flags = flags_reg;
    assign w_cur     = w_cur_reg;
    assign w_prev    = w_prev_reg;
    assign w_prev2   = w_prev2_reg;
    assign w_up1     = w_up1_reg;
    assign w_up2     = w_up2_reg;
    assign w_right   = w_right_reg;
    assign w_left_up = w_left_up_reg;
    assign g_cur     = g_cur_reg;
    assign g_prev    = g_prev_reg;
    assign g_up      = g_up_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (col_ext < side_reg) && (row_ext < side_reg))
    else $error("map position outside the configured side");

    assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_CFG_BITS'(map_reg) < count_reg))
    else $error("map index beyond the configured map count");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (flags_reg.has_main || flags_reg.has_tail || flags_reg.has_fin))
    else $error("job staged without any result");

endmodule

// ===== hdl/nsgs_back.sv =====
module nsgs_back #(
    parameter int WEIGHT_BITS   = nsgs_pkg::DEF_WEIGHT_BITS,
    parameter int GRADIENT_BITS = nsgs_pkg::DEF_GRADIENT_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [nsgs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [nsgs_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   job_avail,
    output logic                                   job_take,
    input  nsgs_pkg::job_flags_t                   job_flags,
    input  logic signed [WEIGHT_BITS-1:0]          w_cur,
    input  logic signed [WEIGHT_BITS-1:0]          w_prev,
    input  logic signed [WEIGHT_BITS-1:0]          w_prev2,
    input  logic signed [WEIGHT_BITS-1:0]          w_up1,
    input  logic signed [WEIGHT_BITS-1:0]          w_up2,
    input  logic signed [WEIGHT_BITS-1:0]          w_right,
    input  logic signed [WEIGHT_BITS-1:0]          w_left_up,
    input  logic signed [GRADIENT_BITS-1:0]        g_cur,
    input  logic signed [GRADIENT_BITS-1:0]        g_prev,
    input  logic signed [GRADIENT_BITS-1:0]        g_up,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [GRADIENT_BITS-1:0]        gradient_out,
    output logic                                   last_of_run,
    output logic                                   end_of_layer
);
    import nsgs_pkg::*;

    localparam int SUM_BITS = ((GRADIENT_BITS > NET_BITS) ? GRADIENT_BITS : NET_BITS) + 1;
    localparam logic signed [SUM_BITS-1:0] G_MAX =
        SUM_BITS'({1'b0, {(GRADIENT_BITS - 1){1'b1}}});
    localparam logic signed [SUM_BITS-1:0] G_MIN = -G_MAX - SUM_BITS'(1);

    localparam logic [1:0] KIND_MAIN = 2'd0;
    localparam logic [1:0] KIND_TAIL = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    logic [DECAY_BITS-1:0]           decay_reg;
    logic [2:0]                      done_reg, done_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [GRADIENT_BITS-1:0] grad_reg;
    logic                            last_reg;
    logic                            end_reg;

    logic [2:0]                      have;
    logic [2:0]                      pend;
    logic [2:0]                      sel_bit;
    logic [1:0]                      kind;
    logic                            last_pick;
    logic                            load;
    logic signed [WEIGHT_BITS-1:0]   center_w;
    logic signed [GRADIENT_BITS-1:0] center_g;
    logic signed [WEIGHT_BITS-1:0]   nb_w [4];
    logic [3:0]                      nb_en;
    logic signed [NET_BITS-1:0]      net;
    logic signed [SUM_BITS-1:0]      sum;
    logic signed [GRADIENT_BITS-1:0] sat;

    function automatic logic signed [NET_BITS-1:0] step_term(
        input logic signed [WEIGHT_BITS-1:0] w,
        input logic signed [WEIGHT_BITS-1:0] nb,
        input logic                          en,
        input logic [DECAY_BITS-1:0]         d
    );
        logic signed [NET_BITS-1:0] mag;
        mag = signed'(NET_BITS'(d));
        if (!en)
        begin
            return '0;
        end
        return (w < nb) ? mag : -mag;
    endfunction

    assign have = {job_flags.has_fin, job_flags.has_tail, job_flags.has_main};
    assign pend = have & ~done_reg;

    // Results of one job leave in raster order: the element one row up, then
    // the left neighbor in the last row, then the map's final element.
    always_comb
    begin
        if (pend[0])
        begin
            kind    = KIND_MAIN;
            sel_bit = 3'b001;
        end
        else if (pend[1])
        begin
            kind    = KIND_TAIL;
            sel_bit = 3'b010;
        end
        else
        begin
            kind    = KIND_FIN;
            sel_bit = 3'b100;
        end
    end

    assign last_pick = ((pend & ~sel_bit) == 3'b000);

    // Neighbor order: left, right, up, down.
    always_comb
    begin
        case (kind)
            KIND_TAIL:
            begin
                center_w = w_prev;
                center_g = g_prev;
                nb_w[0]  = w_prev2;
                nb_w[1]  = w_cur;
                nb_w[2]  = w_left_up;
                nb_w[3]  = w_cur;
                nb_en    = {1'b0, job_flags.row_gt0, 1'b1, job_flags.col_gt1};
            end
            KIND_FIN:
            begin
                center_w = w_cur;
                center_g = g_cur;
                nb_w[0]  = w_prev;
                nb_w[1]  = w_cur;
                nb_w[2]  = w_up1;
                nb_w[3]  = w_cur;
                nb_en    = {1'b0, job_flags.row_gt0, 1'b0, job_flags.col_gt0};
            end
            default:
            begin
                center_w = w_up1;
                center_g = g_up;
                nb_w[0]  = w_left_up;
                nb_w[1]  = w_right;
                nb_w[2]  = w_up2;
                nb_w[3]  = w_cur;
                nb_en    = {1'b1, job_flags.row_gt1, job_flags.right_ok, job_flags.col_gt0};
            end
        endcase
    end

    always_comb
    begin
        net = step_term(center_w, nb_w[0], nb_en[0], decay_reg)
            + step_term(center_w, nb_w[1], nb_en[1], decay_reg)
            + step_term(center_w, nb_w[2], nb_en[2], decay_reg)
            + step_term(center_w, nb_w[3], nb_en[3], decay_reg);
        sum = SUM_BITS'(center_g) + SUM_BITS'(net);
        if (sum > G_MAX)
        begin
            sat = GRADIENT_BITS'(G_MAX);
        end
        else if (sum < G_MIN)
        begin
            sat = GRADIENT_BITS'(G_MIN);
        end
        else
        begin
            sat = sum[GRADIENT_BITS-1:0];
        end
    end

    assign load     = job_avail && (!out_valid_reg || pop);
    assign job_take = load && last_pick;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            done_next      = last_pick ? 3'b000 : (done_reg | sel_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= '0;
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_DECAY))
            begin
                decay_reg <= cfg_data[DECAY_BITS-1:0];
            end
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grad_reg <= sat;
            last_reg <= last_pick;
            end_reg  <= (kind == KIND_FIN) && job_flags.last_map;
        end
    end

    assign empty        = !out_valid_reg;
    assign gradient_out = grad_reg;
    assign last_of_run  = last_reg;
    assign end_of_layer = end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        job_avail |-> ((done_reg & ~have) == 3'b000))
    else $error("result marked done that the job does not have");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_avail |-> (have != 3'b000))
    else $error("queued job carries no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_reg) |-> last_reg)
    else $error("end of layer on a beat that is not the last of its run");

endmodule

// ===== hdl/neighbor_sign_gradient_stencil.sv =====
// Throughput: one item per cycle while full is low; in a map's last row each item after the
// first yields two results and the final element three, and the single result register then
// paces the items by the results they yield. Reset clears positions, queue and output valid, and
// sets decay 0, side 16 (MAX_SIDE if smaller), one map; the line stores are not cleared and need
// no clearing pass, since only in-map entries are used.
module neighbor_sign_gradient_stencil #(
    parameter int MAX_SIDE      = nsgs_pkg::DEF_MAX_SIDE,
    parameter int WEIGHT_BITS   = nsgs_pkg::DEF_WEIGHT_BITS,
    parameter int GRADIENT_BITS = nsgs_pkg::DEF_GRADIENT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [WEIGHT_BITS-1:0]       weight_value,
    input  logic signed [GRADIENT_BITS-1:0]     gradient_in,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [GRADIENT_BITS-1:0]     gradient_out,
    output logic                                last_of_run,
    output logic                                end_of_layer,
    input  logic                                cfg_write,
    input  logic [nsgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nsgs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import nsgs_pkg::*;

    localparam int JOB_BITS = FLAGS_BITS + 7 * WEIGHT_BITS + 3 * GRADIENT_BITS;

    logic                            fr_valid;
    logic                            q_full;
    logic                            q_empty;
    logic                            bk_take;
    logic [JOB_BITS-1:0]             q_in;
    logic [JOB_BITS-1:0]             q_out;

    job_flags_t                      fr_flags, bk_flags;
    logic signed [WEIGHT_BITS-1:0]   fr_w_cur, fr_w_prev, fr_w_prev2, fr_w_up1;
    logic signed [WEIGHT_BITS-1:0]   fr_w_up2, fr_w_right, fr_w_left_up;
    logic signed [GRADIENT_BITS-1:0] fr_g_cur, fr_g_prev, fr_g_up;
    logic signed [WEIGHT_BITS-1:0]   bk_w_cur, bk_w_prev, bk_w_prev2, bk_w_up1;
    logic signed [WEIGHT_BITS-1:0]   bk_w_up2, bk_w_right, bk_w_left_up;
    logic signed [GRADIENT_BITS-1:0] bk_g_cur, bk_g_prev, bk_g_up;

    nsgs_front #(
        .MAX_SIDE      (MAX_SIDE),
        .WEIGHT_BITS   (WEIGHT_BITS),
        .GRADIENT_BITS (GRADIENT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .weight_value (weight_value),
        .gradient_in  (gradient_in),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_valid    (fr_valid),
        .job_ready    (!q_full),
        .job_flags    (fr_flags),
        .w_cur        (fr_w_cur),
        .w_prev       (fr_w_prev),
        .w_prev2      (fr_w_prev2),
        .w_up1        (fr_w_up1),
        .w_up2        (fr_w_up2),
        .w_right      (fr_w_right),
        .w_left_up    (fr_w_left_up),
        .g_cur        (fr_g_cur),
        .g_prev       (fr_g_prev),
        .g_up         (fr_g_up)
    );

    assign q_in = {fr_flags, fr_w_cur, fr_w_prev, fr_w_prev2, fr_w_up1, fr_w_up2,
                   fr_w_right, fr_w_left_up, fr_g_cur, fr_g_prev, fr_g_up};

    nsgs_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fr_valid),
        .push_data (q_in),
        .full      (q_full),
        .pop       (bk_take),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    assign {bk_flags, bk_w_cur, bk_w_prev, bk_w_prev2, bk_w_up1, bk_w_up2,
            bk_w_right, bk_w_left_up, bk_g_cur, bk_g_prev, bk_g_up} = q_out;

    nsgs_back #(
        .WEIGHT_BITS   (WEIGHT_BITS),
        .GRADIENT_BITS (GRADIENT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .job_avail    (!q_empty),
        .job_take     (bk_take),
        .job_flags    (bk_flags),
        .w_cur        (bk_w_cur),
        .w_prev       (bk_w_prev),
        .w_prev2      (bk_w_prev2),
        .w_up1        (bk_w_up1),
        .w_up2        (bk_w_up2),
        .w_right      (bk_w_right),
        .w_left_up    (bk_w_left_up),
        .g_cur        (bk_g_cur),
        .g_prev       (bk_g_prev),
        .g_up         (bk_g_up),
        .empty        (empty),
        .pop          (pop),
        .gradient_out (gradient_out),
        .last_of_run  (last_of_run),
        .end_of_layer (end_of_layer)
    );

endmodule

// ===== sim/gradient_stencil_checker.sv =====
module gradient_stencil_checker #(
    parameter int MAX_SIDE      = nsgs_pkg::DEF_MAX_SIDE,
    parameter int WEIGHT_BITS   = nsgs_pkg::DEF_WEIGHT_BITS,
    parameter int GRADIENT_BITS = nsgs_pkg::DEF_GRADIENT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic signed [WEIGHT_BITS-1:0]       weight_value,
    input  logic signed [GRADIENT_BITS-1:0]     gradient_in,
    input  logic                                empty,
    input  logic                                pop,
    input  logic signed [GRADIENT_BITS-1:0]     gradient_out,
    input  logic                                last_of_run,
    input  logic                                end_of_layer,
    input  logic                                cfg_write,
    input  logic [nsgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [nsgs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  pending,
    output int                                  fail_count
);
    import nsgs_pkg::*;

    localparam int WEIGHT_DEPTH   = 2 * MAX_SIDE + 1;
    localparam int GRADIENT_DEPTH = MAX_SIDE + 1;

    typedef struct {
        logic signed [GRADIENT_BITS-1:0] gradient;
        logic                            last;
        logic                            layer_end;
    } smoothed_beat_t;

    smoothed_beat_t expected_grads[$];

    logic signed [WEIGHT_BITS-1:0]   weight_line [0:WEIGHT_DEPTH-1];
    logic signed [GRADIENT_BITS-1:0] gradient_line [0:GRADIENT_DEPTH-1];
    logic [DECAY_BITS-1:0]           decay;
    logic [SIDE_CFG_BITS-1:0]        side_cfg;
    logic [COUNT_CFG_BITS-1:0]       count_cfg;
    int unsigned                     row_pos;
    int unsigned                     col_pos;
    int unsigned                     map_pos;
    int                              mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("t=%0t mismatch: %s", $time, msg);
    endtask

    function automatic longint neighbor_step(input longint w, input longint nb);
        return (w < nb) ? longint'(decay) : -longint'(decay);
    endfunction

    // Net decay over the in-map neighbors, added once and clamped to the gradient range.
    function automatic logic signed [GRADIENT_BITS-1:0] smoothed_gradient(
        input int unsigned r, input int unsigned c, input int unsigned e, input int unsigned s);
        longint w;
        longint total;
        longint hi;
        longint lo;
        w = weight_line[e % WEIGHT_DEPTH];
        total = gradient_line[e % GRADIENT_DEPTH];
        hi = (longint'(1) <<< (GRADIENT_BITS - 1)) - 1;
        lo = -hi - 1;
        if (c > 0)
            total += neighbor_step(w, weight_line[(e - 1) % WEIGHT_DEPTH]);
        if (c + 1 < s)
            total += neighbor_step(w, weight_line[(e + 1) % WEIGHT_DEPTH]);
        if (r > 0)
            total += neighbor_step(w, weight_line[(e - s) % WEIGHT_DEPTH]);
        if (r + 1 < s)
            total += neighbor_step(w, weight_line[(e + s) % WEIGHT_DEPTH]);
        if (total > hi)
            total = hi;
        if (total < lo)
            total = lo;
        return total[GRADIENT_BITS-1:0];
    endfunction

    task automatic predict_smoothing(input logic signed [WEIGHT_BITS-1:0] w,
                                     input logic signed [GRADIENT_BITS-1:0] g);
        int unsigned    s;
        int unsigned    n;
        int unsigned    r;
        int unsigned    c;
        int unsigned    p;
        int unsigned    k;
        int unsigned    e;
        int unsigned    out_row[3];
        int unsigned    out_col[3];
        bit             last_row;
        bit             last_map;
        smoothed_beat_t beat;
        s = (side_cfg == 0) ? 1 : ((side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg);
        n = (count_cfg == 0) ? 1 : ((count_cfg > MAP_LIMIT) ? MAP_LIMIT : count_cfg);
        if (row_pos >= s || col_pos >= s)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        if (map_pos >= n)
            map_pos = 0;
        r = row_pos;
        c = col_pos;
        p = r * s + c;
        weight_line[p % WEIGHT_DEPTH] = w;
        gradient_line[p % GRADIENT_DEPTH] = g;
        last_row = (r + 1 == s);
        last_map = (map_pos + 1 == n);

        // The element above is complete now; in the last row the left one is too,
        // and the map's final element closes itself.
        k = 0;
        if (r > 0)
        begin
            out_row[k] = r - 1;
            out_col[k] = c;
            k++;
        end
        if (last_row && c > 0)
        begin
            out_row[k] = r;
            out_col[k] = c - 1;
            k++;
        end
        if (last_row && c + 1 == s)
        begin
            out_row[k] = r;
            out_col[k] = c;
            k++;
        end
        for (int i = 0; i < k; i++)
        begin
            e = out_row[i] * s + out_col[i];
            beat.gradient = smoothed_gradient(out_row[i], out_col[i], e, s);
            beat.last = (i + 1 == k);
            beat.layer_end = last_map && (out_row[i] + 1 == s) && (out_col[i] + 1 == s);
            expected_grads.push_back(beat);
        end

        if (c + 1 < s)
            col_pos = c + 1;
        else
        begin
            col_pos = 0;
            if (r + 1 < s)
                row_pos = r + 1;
            else
            begin
                row_pos = 0;
                map_pos = last_map ? 0 : map_pos + 1;
            end
        end
    endtask

    task automatic check_result();
        smoothed_beat_t beat;
        if (expected_grads.size() == 0)
            report_mismatch($sformatf("result beat with nothing expected, gradient %0d",
                                      gradient_out));
        else
        begin
            beat = expected_grads.pop_front();
            if (gradient_out !== beat.gradient)
                report_mismatch($sformatf("gradient_out %0d, expected %0d",
                                          gradient_out, beat.gradient));
            if (last_of_run !== beat.last)
                report_mismatch($sformatf("last_of_run %b, expected %b",
                                          last_of_run, beat.last));
            if (end_of_layer !== beat.layer_end)
                report_mismatch($sformatf("end_of_layer %b, expected %b",
                                          end_of_layer, beat.layer_end));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WEIGHT_DEPTH; i++)
                weight_line[i] = '0;
            for (int i = 0; i < GRADIENT_DEPTH; i++)
                gradient_line[i] = '0;
            decay = '0;
            side_cfg = SIDE_CFG_BITS'(SIDE_RESET);
            count_cfg = COUNT_CFG_BITS'(COUNT_RESET);
            row_pos = 0;
            col_pos = 0;
            map_pos = 0;
            expected_grads.delete();
            pending <= 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DECAY:
                        decay = cfg_data[DECAY_BITS-1:0];
                    REG_SIDE:
                    begin
                        side_cfg = cfg_data[SIDE_CFG_BITS-1:0];
                        row_pos = 0;
                        col_pos = 0;
                        map_pos = 0;
                    end
                    REG_COUNT:
                    begin
                        count_cfg = cfg_data[COUNT_CFG_BITS-1:0];
                        row_pos = 0;
                        col_pos = 0;
                        map_pos = 0;
                    end
                    default:
                        ;
                endcase
            end
            if (push && !full)
                predict_smoothing(weight_value, gradient_in);
            pending <= expected_grads.size();
        end
    end

endmodule

// ===== sim/neighbor_sign_gradient_stencil_test.sv =====
module neighbor_sign_gradient_stencil_test;

    import nsgs_pkg::*;

    localparam int WB = DEF_WEIGHT_BITS;
    localparam int GB = DEF_GRADIENT_BITS;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic signed [WB-1:0]        weight_value;
    logic signed [GB-1:0]        gradient_in;
    logic                        empty;
    logic                        pop = 1'b0;
    logic signed [GB-1:0]        gradient_out;
    logic                        last_of_run;
    logic                        end_of_layer;
    logic                        cfg_write;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;
    int                          pending;
    int                          fail_count;

    int                          burst_left = 0;
    int                          gap_max = 0;
    logic [7:0]                  pop_tick = '0;
    logic [1:0]                  pop_mode = '0;

    neighbor_sign_gradient_stencil u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .weight_value (weight_value),
        .gradient_in  (gradient_in),
        .empty        (empty),
        .pop          (pop),
        .gradient_out (gradient_out),
        .last_of_run  (last_of_run),
        .end_of_layer (end_of_layer),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gradient_stencil_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .weight_value (weight_value),
        .gradient_in  (gradient_in),
        .empty        (empty),
        .pop          (pop),
        .gradient_out (gradient_out),
        .last_of_run  (last_of_run),
        .end_of_layer (end_of_layer),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    always #5 clk = ~clk;

    // The receiver switches between stall patterns each time pop_tick wraps to zero.
    always @(posedge clk)
    begin
        pop_tick <= pop_tick + 8'd1;
        if (pop_tick == 8'd0)
            pop_mode <= 2'($urandom_range(0, 3));
        case (pop_mode)
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= 1'($urandom_range(0, 1));
            2'd2:    pop <= (pop_tick[1:0] == 2'd0);
            default: pop <= ($urandom_range(0, 15) == 0);
        endcase
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_layer(input int decay, input int side, input int maps);
        write_reg(REG_DECAY, CFG_DATA_BITS'(decay));
        write_reg(REG_SIDE, CFG_DATA_BITS'(side));
        write_reg(REG_COUNT, CFG_DATA_BITS'(maps));
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic signed [WB-1:0] w, input logic signed [GB-1:0] g);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        push <= 1'b1;
        weight_value <= w;
        gradient_in <= g;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
    endtask

    // Stop sending, let every expected result come out, then allow for items still in
    // flight that cause no result.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_random(input int count, input int pause_at);
        logic signed [WB-1:0] w;
        logic signed [GB-1:0] g;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at && i > 0)
            begin
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            // Narrow weight ranges make ties with neighbors common.
            case ($urandom_range(0, 3))
                0:
                    w = WB'($urandom);
                1:
                begin
                    w = WB'($urandom_range(0, 2));
                    w = w - 1;
                end
                2:
                    case ($urandom_range(0, 3))
                        0:       w = 16'sh7FFF;
                        1:       w = 16'sh8000;
                        2:       w = 16'sh0000;
                        default: w = -16'sd1;
                    endcase
                default:
                    w = WB'($urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 3))
                0:       g = GB'($urandom);
                1:       g = 32'h7FFF_FFFF - GB'($urandom_range(0, 300000));
                2:       g = 32'h8000_0000 + GB'($urandom_range(0, 300000));
                default: g = GB'($urandom_range(0, 2000)) - 1000;
            endcase
            send_item(w, g);
        end
    endtask

    initial
    begin
        int side;
        int maps;
        int decay;
        int side_eff;
        int whole;
        int items;
        int random_items;

        rst_n = 1'b0;
        push = 1'b0;
        weight_value = '0;
        gradient_in = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DECAY;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full decay on a 3x3 map with extreme weights, ties and saturating gradients.
        set_layer(16'hFFFF, 3, 0);
        send_item(16'sh7FFF, 32'sh7FFF_FFFF);
        send_item(16'sh8000, 32'sh7FFF_FFFF);
        send_item(16'sh0000, 32'sh8000_0000);
        send_item(16'sh0000, 32'sh0000_0000);
        send_item(16'sh0000, 32'sh8000_0000);
        send_item(16'sh7FFF, 32'sh0000_0005);
        send_item(16'sh8000, 32'sh8000_0001);
        send_item(-16'sd1, 32'sh7FFF_FFFE);
        send_item(16'sh7FFF, -32'sd1);
        drain();

        // Side zero acts as one: each item comes back unchanged, three maps per layer.
        write_reg(REG_UNUSED, 16'hFFFF);
        set_layer(16'h1234, 0, 3);
        send_item(16'sh1234, 32'sh1234_5678);
        send_item(16'sh8000, 32'sh8000_0000);
        send_item(16'sh7FFF, 32'sh7FFF_FFFF);
        send_item(16'sh0001, 32'sh0000_0001);
        drain();

        // Equal weights everywhere: every neighbor is a tie and subtracts.
        set_layer(1, 2, 2);
        for (int i = 0; i < 8; i++)
            send_item(16'sh0400, GB'(i) - 4);
        drain();

        // Side register fully set saturates to the largest map; pause once mid-map.
        gap_max = 3;
        set_layer($urandom_range(0, 65535), 16'hFFFF, 1);
        send_random(80, 40);
        drain();

        // One-by-one maps with the map count saturated: no beat ends the layer early.
        gap_max = 0;
        set_layer(7, 1, 16'hFFFF);
        send_random(20, -1);
        drain();

        random_items = 0;
        while (random_items < 150)
        begin
            case ($urandom_range(0, 9))
                0:       side = 0;
                1:       side = $urandom_range(6, 9);
                default: side = $urandom_range(1, 5);
            endcase
            maps = (side > 5) ? 1 : $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       decay = 0;
                1:       decay = 65535;
                2:       decay = $urandom_range(0, 65535);
                default: decay = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            set_layer(decay, side, maps);
            side_eff = (side == 0) ? 1 : side;
            whole = ((maps == 0) ? 1 : maps) * side_eff * side_eff;
            items = ($urandom_range(0, 3) != 0) ? whole : $urandom_range(1, whole);
            send_random(items, ($urandom_range(0, 4) == 0) ? $urandom_range(1, items) : -1);
            random_items += items;
            drain();
            // A decay write keeps the position, so a broken-off layer can be finished.
            if (items < whole && $urandom_range(0, 1) == 1)
            begin
                write_reg(REG_DECAY, CFG_DATA_BITS'($urandom));
                cfg_write <= 1'b0;
                send_random(whole - items, -1);
                random_items += whole - items;
                drain();
            end
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/nsgs_pkg.sv
hdl/nsgs_fifo.sv
hdl/nsgs_front.sv
hdl/nsgs_back.sv
hdl/neighbor_sign_gradient_stencil.sv
sim/gradient_stencil_checker.sv
sim/neighbor_sign_gradient_stencil_test.sv
